// ===== sv/ffha_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types and constants of the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

    localparam int TABLE_ENTRIES_DEF = 256;
    localparam int HEADER_BYTES_DEF  = 8;
    localparam int FOOTER_BYTES_DEF  = 8;

    localparam int EXT_W = 36;

    localparam logic [11:0] PAGE_MASK_LOW  = 12'hfff;
    localparam logic [31:0] PAGE_MASK_HIGH = 32'hfffff000;
    localparam logic [12:0] PAGE_BYTES     = 13'h1000;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_ZERO     = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_TABLE    = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    localparam logic [1:0] REG_HEAP_START = 2'd0;
    localparam logic [1:0] REG_HEAP_INIT  = 2'd1;
    localparam logic [1:0] REG_HEAP_LIMIT = 2'd2;

    typedef struct packed {
        logic        opcode;
        logic [31:0] alloc_size;
        logic        align_page;
        logic [31:0] address;
    } in_beat_t;

    typedef struct packed {
        logic [31:0] result_address;
        logic [2:0]  status;
        logic [31:0] heap_end_now;
    } out_beat_t;

endpackage

// ===== sv/ffha_gap_fit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_gap_fit
// Checks whether a gap holds a block footprint, with optional page alignment.
// ----------------------------------------------------------------------------
module ffha_gap_fit #(
    parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
    input  logic [ffha_pkg::EXT_W-1:0] gap_start,
    input  logic [31:0]                gap_end,
    input  logic [33:0]                footprint,
    input  logic                       align,
    output logic                       fits,
    output logic [31:0]                hole
);
    logic [ffha_pkg::EXT_W-1:0] hdr_pos;
    logic [11:0]                low;
    logic [ffha_pkg::EXT_W-1:0] bumped;
    logic [ffha_pkg::EXT_W-1:0] start_adj;
    logic [ffha_pkg::EXT_W-1:0] end_ext;

    always_comb begin
        end_ext = ffha_pkg::EXT_W'(gap_end);
        hdr_pos = gap_start + ffha_pkg::EXT_W'(HEADER_BYTES);
        low     = hdr_pos[11:0] & ffha_pkg::PAGE_MASK_LOW;
        bumped  = gap_start + ffha_pkg::EXT_W'(ffha_pkg::PAGE_BYTES - {1'b0, low});
        start_adj = gap_start;
        if (align && low != 12'd0) begin
            start_adj = (bumped >= end_ext) ? end_ext : bumped;
        end
        fits = (end_ext >= start_adj) &&
               ((end_ext - start_adj) >= ffha_pkg::EXT_W'(footprint));
        hole = start_adj[31:0];
    end
endmodule

// ===== sv/first_fit_heap_allocator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_core
// First-fit allocator over an address-sorted block table in one RAM.
// ----------------------------------------------------------------------------
// One request at a time. Every table access goes through one RAM with a
// registered read port and a separate write port, so each entry visited takes
// a read state and an evaluate or write state. An allocate scans for the first
// gap that fits, growing the heap and rescanning if none fits, then shifts
// later entries up to insert. A free finds the entry of the pointer's header
// and shifts later entries down, or reports not found. Trivial cases go from
// idle straight to done. No clearing pass is needed after reset. A result
// waits in the output register while the next request is accepted.
module first_fit_heap_allocator_core #(
    parameter int TABLE_ENTRIES = ffha_pkg::TABLE_ENTRIES_DEF,
    parameter int HEADER_BYTES  = ffha_pkg::HEADER_BYTES_DEF,
    parameter int FOOTER_BYTES  = ffha_pkg::FOOTER_BYTES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ffha_pkg::in_beat_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ffha_pkg::out_beat_t m_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int CW = IW + 1;
    localparam int XW = ffha_pkg::EXT_W;
    localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);

    typedef enum logic [14:0] {
        S_IDLE    = 15'b000000000000001,
        S_SCAN_RD = 15'b000000000000010,
        S_SCAN_EV = 15'b000000000000100,
        S_TAIL    = 15'b000000000001000,
        S_GROW    = 15'b000000000010000,
        S_POS_RD  = 15'b000000000100000,
        S_POS_EV  = 15'b000000001000000,
        S_INS_RD  = 15'b000000010000000,
        S_INS_WR  = 15'b000000100000000,
        S_INS_PUT = 15'b000001000000000,
        S_FREE_RD = 15'b000010000000000,
        S_FREE_EV = 15'b000100000000000,
        S_DEL_RD  = 15'b001000000000000,
        S_DEL_WR  = 15'b010000000000000,
        S_DONE    = 15'b100000000000000
    } state_t;

    state_t              state_reg, state_next;
    logic [31:0]         heap_start_reg, heap_init_reg, heap_limit_reg;
    logic [31:0]         heap_end_reg, heap_end_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       idx_reg, idx_next;
    logic [CW-1:0]       j_reg, j_next;
    logic [XW-1:0]       s_reg, s_next;
    logic [33:0]         fp_reg, fp_next;
    logic [31:0]         hole_reg, hole_next;
    ffha_pkg::in_beat_t  req_reg, req_next;
    logic [31:0]         res_addr_reg, res_addr_next;
    logic [2:0]          res_st_reg, res_st_next;
    logic                m_valid_reg, m_valid_next;
    ffha_pkg::out_beat_t m_data_reg, m_data_next;

    logic [63:0]         mem [TABLE_ENTRIES];
    logic [63:0]         rd_data_reg;
    logic [IW-1:0]       rd_idx;
    logic                wr_en;
    logic [IW-1:0]       wr_idx;
    logic [63:0]         wr_data;

    logic [31:0]         rd_a, rd_p;
    logic [31:0]         fit_end;
    logic                fit_ok;
    logic [31:0]         fit_hole;
    logic [XW-1:0]       blk_end;
    logic [31:0]         heap_used;
    logic [34:0]         grown_size, new_round;
    logic [32:0]         span;
    logic [31:0]         hdr_addr;
    logic                cfg_wr;

    assign rd_a = rd_data_reg[63:32];
    assign rd_p = rd_data_reg[31:0];

    ffha_gap_fit #(.HEADER_BYTES(HEADER_BYTES)) u_fit (
        .gap_start (s_reg),
        .gap_end   (fit_end),
        .footprint (fp_reg),
        .align     (req_reg.align_page),
        .fits      (fit_ok),
        .hole      (fit_hole)
    );

    assign fit_end    = (state_reg == S_TAIL) ? heap_end_reg : rd_a;
    assign blk_end    = XW'(rd_a) + XW'(HEADER_BYTES) + XW'(rd_p) + XW'(FOOTER_BYTES);
    assign heap_used  = heap_end_reg - heap_start_reg;
    assign grown_size = 35'(heap_used) + 35'(fp_reg);
    assign new_round  = (grown_size[11:0] != 12'd0)
                      ? {grown_size[34:12] + 23'd1, 12'd0} : grown_size;
    assign span     = (heap_limit_reg >= heap_start_reg)
                    ? 33'(heap_limit_reg - heap_start_reg) : 33'd0;
    assign hdr_addr = req_reg.address - 32'(HEADER_BYTES);

    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_comb begin
        case (paddr[3:2])
            ffha_pkg::REG_HEAP_START: prdata = heap_start_reg;
            ffha_pkg::REG_HEAP_INIT:  prdata = heap_init_reg;
            ffha_pkg::REG_HEAP_LIMIT: prdata = heap_limit_reg;
            default:                  prdata = 32'd0;
        endcase
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        case (state_reg)
            S_SCAN_RD, S_POS_RD, S_FREE_RD: rd_idx = idx_reg[IW-1:0];
            S_INS_RD:                       rd_idx = IW'(j_reg - CW'(1));
            S_DEL_RD:                       rd_idx = IW'(j_reg + CW'(1));
            default:                        rd_idx = idx_reg[IW-1:0];
        endcase
        wr_en   = (state_reg == S_INS_WR) || (state_reg == S_DEL_WR) ||
                  (state_reg == S_INS_PUT);
        wr_idx  = j_reg[IW-1:0];
        wr_data = (state_reg == S_INS_PUT) ? {hole_reg, req_reg.alloc_size} : rd_data_reg;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_data;
        end
        rd_data_reg <= mem[rd_idx];
    end

    always_comb begin
        state_next    = state_reg;
        heap_end_next = heap_end_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        j_next        = j_reg;
        s_next        = s_reg;
        fp_next       = fp_reg;
        hole_next     = hole_reg;
        req_next      = req_reg;
        res_addr_next = res_addr_reg;
        res_st_next   = res_st_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    req_next      = s_data;
                    res_addr_next = 32'd0;
                    res_st_next   = ffha_pkg::ST_OK;
                    idx_next      = '0;
                    s_next        = XW'(heap_start_reg);
                    fp_next       = 34'(HEADER_BYTES) + 34'(s_data.alloc_size)
                                  + 34'(FOOTER_BYTES);
                    state_next    = S_DONE;
                    if (s_data.opcode == ffha_pkg::OP_ALLOC) begin
                        if (s_data.alloc_size == 32'd0) begin
                            res_st_next = ffha_pkg::ST_ZERO;
                        end else if (count_reg >= FULL_COUNT) begin
                            res_st_next = ffha_pkg::ST_TABLE;
                        end else if (count_reg == '0) begin
                            state_next = S_TAIL;
                        end else begin
                            state_next = S_SCAN_RD;
                        end
                    end else begin
                        if (s_data.address == 32'd0) begin
                            res_st_next = ffha_pkg::ST_OK;
                        end else if (s_data.address < 32'(HEADER_BYTES) ||
                                     count_reg == '0) begin
                            res_st_next = ffha_pkg::ST_NOTFOUND;
                        end else begin
                            state_next = S_FREE_RD;
                        end
                    end
                end
            end
            S_SCAN_RD: state_next = S_SCAN_EV;
            S_SCAN_EV: begin
                if (s_reg < XW'(rd_a) && fit_ok) begin
                    hole_next  = fit_hole;
                    idx_next   = '0;
                    state_next = S_POS_RD;
                end else begin
                    s_next     = blk_end;
                    idx_next   = idx_reg + CW'(1);
                    state_next = ((idx_reg + CW'(1)) == count_reg) ? S_TAIL : S_SCAN_RD;
                end
            end
            S_TAIL: begin
                if (fit_ok) begin
                    hole_next = fit_hole;
                    idx_next  = '0;
                    if (count_reg == '0) begin
                        j_next     = '0;
                        state_next = S_INS_PUT;
                    end else begin
                        state_next = S_POS_RD;
                    end
                end else begin
                    state_next = S_GROW;
                end
            end
            S_GROW: begin
                if (35'(span) <= new_round) begin
                    res_st_next = ffha_pkg::ST_FULL;
                    state_next  = S_DONE;
                end else begin
                    heap_end_next = heap_start_reg + new_round[31:0];
                    s_next        = XW'(heap_start_reg);
                    idx_next      = '0;
                    state_next    = (count_reg == '0) ? S_TAIL : S_SCAN_RD;
                end
            end
            S_POS_RD: state_next = S_POS_EV;
            S_POS_EV: begin
                if (rd_a <= hole_reg) begin
                    idx_next = idx_reg + CW'(1);
                    if ((idx_reg + CW'(1)) == count_reg) begin
                        j_next     = count_reg;
                        state_next = S_INS_PUT;
                    end else begin
                        state_next = S_POS_RD;
                    end
                end else begin
                    j_next     = count_reg;
                    state_next = S_INS_RD;
                end
            end
            S_INS_RD: state_next = S_INS_WR;
            S_INS_WR: begin
                j_next     = j_reg - CW'(1);
                state_next = ((j_reg - CW'(1)) == idx_reg) ? S_INS_PUT : S_INS_RD;
            end
            S_INS_PUT: begin
                count_next    = count_reg + CW'(1);
                res_addr_next = hole_reg + 32'(HEADER_BYTES);
                res_st_next   = ffha_pkg::ST_OK;
                state_next    = S_DONE;
            end
            S_FREE_RD: state_next = S_FREE_EV;
            S_FREE_EV: begin
                if (rd_a == hdr_addr) begin
                    j_next = idx_reg;
                    if ((idx_reg + CW'(1)) == count_reg) begin
                        count_next = count_reg - CW'(1);
                        state_next = S_DONE;
                    end else begin
                        state_next = S_DEL_RD;
                    end
                end else begin
                    idx_next = idx_reg + CW'(1);
                    if ((idx_reg + CW'(1)) == count_reg) begin
                        res_st_next = ffha_pkg::ST_NOTFOUND;
                        state_next  = S_DONE;
                    end else begin
                        state_next = S_FREE_RD;
                    end
                end
            end
            S_DEL_RD: state_next = S_DEL_WR;
            S_DEL_WR: begin
                j_next = j_reg + CW'(1);
                if ((j_reg + CW'(2)) == count_reg) begin
                    count_next = count_reg - CW'(1);
                    state_next = S_DONE;
                end else begin
                    state_next = S_DEL_RD;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next               = 1'b1;
                    m_data_next.result_address = res_addr_reg;
                    m_data_next.status         = res_st_reg;
                    m_data_next.heap_end_now   = heap_end_reg;
                    state_next                 = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (cfg_wr && paddr[3:2] == ffha_pkg::REG_HEAP_INIT) begin
            heap_end_next = pwdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            heap_start_reg <= 32'd0;
            heap_init_reg  <= 32'd0;
            heap_limit_reg <= 32'd0;
            heap_end_reg   <= 32'd0;
            count_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg    <= state_next;
            heap_end_reg <= heap_end_next;
            count_reg    <= count_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_wr) begin
                case (paddr[3:2])
                    ffha_pkg::REG_HEAP_START: heap_start_reg <= pwdata;
                    ffha_pkg::REG_HEAP_INIT:  heap_init_reg  <= pwdata;
                    ffha_pkg::REG_HEAP_LIMIT: heap_limit_reg <= pwdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        j_reg        <= j_next;
        s_reg        <= s_next;
        fp_reg       <= fp_next;
        hole_reg     <= hole_next;
        req_reg      <= req_next;
        res_addr_reg <= res_addr_next;
        res_st_reg   <= res_st_next;
        m_data_reg   <= m_data_next;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_COUNT)
        else $error("block count beyond table size");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != $past(count_reg)) |->
        ((count_reg == $past(count_reg) + CW'(1)) ||
         (count_reg == $past(count_reg) - CW'(1))))
        else $error("block count jumped");

    a_write_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (state_reg != S_IDLE && state_reg != S_DONE))
        else $error("table write outside insert or delete");

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg != S_IDLE))
        else $error("accepted request did not start");
`endif
endmodule
